FILE: src/hvn_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and limits of the heightmap vertex normal core.
package hvn_pkg;

    localparam int MAX_SIDE = 1024;
    localparam int MIN_SIDE = 2;
    localparam int IDX_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W   = 11;
    localparam int H_W      = 16;
    localparam int N_W      = 18;
    localparam int Y_W      = 3;
    localparam int SIDE_RESET = 257;

    typedef logic signed [H_W-1:0] height_t;
    typedef logic signed [N_W-1:0] comp_t;
    typedef logic [Y_W-1:0]        ycount_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [SIDE_W-1:0]     side_t;

    typedef struct packed {
        height_t hu;
        height_t hl;
        height_t h;
        height_t hr;
        height_t hd;
        idx_t    vr;
        idx_t    vc;
    } stencil_t;

    typedef struct packed {
        comp_t   x;
        ycount_t y;
        comp_t   z;
        logic    frame_end;
    } normal_t;

endpackage

FILE: src/heightmap_vertex_normals_core.sv
`timescale 1ns / 1ps
// Top level of the streaming heightmap vertex normal core.
// Heights enter in raster order, one request per cycle while in_ready is high, and the
// normal of a vertex leaves as soon as the height below it has arrived, so output runs
// one row behind the input; on the last row one height also completes the vertex to its
// left, and the final height of the grid completes three. The output port carries one
// normal per cycle while out_ready allows, which sets the rate: a height is held off until
// the stage emits the last normal released by the height before it, so on the last row
// heights wait for the output. Each height passes through one stage made of the registered
// reads of two ping-pong line buffers, each read at the current and the next column, so a
// normal reaches the output through that stage and then the output register. A write of
// the side register restarts the grid at row 0, column 0; values below 2 act as 2 and
// values above 1024 act as 1024. The line buffers need no clearing after reset.
module heightmap_vertex_normals_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  hvn_pkg::side_t        cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hvn_pkg::height_t      height,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hvn_pkg::comp_t        normal_x,
    output hvn_pkg::ycount_t      normal_y,
    output hvn_pkg::comp_t        normal_z,
    output hvn_pkg::idx_t         vertex_row,
    output hvn_pkg::idx_t         vertex_col,
    output logic                  frame_end,
    output logic                  run_last
);

    localparam int KIND_N = 3;
    localparam logic [KIND_N-1:0] KIND_ABOVE    = 3'b001;
    localparam logic [KIND_N-1:0] KIND_LAST_LAG = 3'b010;
    localparam logic [KIND_N-1:0] KIND_LAST_END = 3'b100;

    hvn_pkg::height_t buf0_mem [0:hvn_pkg::MAX_SIDE-1];
    hvn_pkg::height_t buf1_mem [0:hvn_pkg::MAX_SIDE-1];

    hvn_pkg::side_t   side_reg, side_next, side;
    hvn_pkg::idx_t    row_reg, row_next;
    hvn_pkg::idx_t    col_reg, col_next;
    logic             sel_reg, sel_next;
    logic             accept;
    hvn_pkg::idx_t    addr_n;
    logic             last_row;
    logic             last_col;
    logic [KIND_N-1:0] mask_in;

    hvn_pkg::height_t rd0_c_reg, rd0_n_reg, rd1_c_reg, rd1_n_reg;
    hvn_pkg::height_t s_h_reg;
    hvn_pkg::idx_t    s_row_reg;
    hvn_pkg::idx_t    s_col_reg;
    logic             s_sel_reg;
    hvn_pkg::height_t ml_reg, hl1_reg, hl2_reg;
    logic [KIND_N-1:0] s_mask_reg, s_mask_next;

    hvn_pkg::height_t s_t, s_m, s_mr;
    logic [KIND_N-1:0] pick;
    logic [KIND_N-1:0] mask_left;
    logic             out_free;
    logic             emit;
    hvn_pkg::stencil_t st;
    hvn_pkg::normal_t  nrm;

    logic             out_valid_reg, out_valid_next;
    hvn_pkg::comp_t   normal_x_reg, normal_z_reg;
    hvn_pkg::ycount_t normal_y_reg;
    hvn_pkg::idx_t    vertex_row_reg, vertex_col_reg;
    logic             frame_end_reg, run_last_reg;

    assign accept = in_valid && in_ready;
    assign addr_n = col_reg + hvn_pkg::idx_t'(1);

    always_comb
    begin
        if (side_reg < hvn_pkg::side_t'(hvn_pkg::MIN_SIDE))
        begin
            side = hvn_pkg::side_t'(hvn_pkg::MIN_SIDE);
        end
        else if (side_reg > hvn_pkg::side_t'(hvn_pkg::MAX_SIDE))
        begin
            side = hvn_pkg::side_t'(hvn_pkg::MAX_SIDE);
        end
        else
        begin
            side = side_reg;
        end
    end

    // Position of the incoming request and the results it will release.
    always_comb
    begin
        last_row = (({1'b0, row_reg} + hvn_pkg::side_t'(1)) == side);
        last_col = (({1'b0, col_reg} + hvn_pkg::side_t'(1)) == side);
        mask_in  = {last_row && last_col, last_row && (col_reg != '0), row_reg != '0};

        side_next = side_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        sel_next  = sel_reg;
        if (cfg_we)
        begin
            side_next = cfg_wdata;
            row_next  = '0;
            col_next  = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                sel_next = ~sel_reg;
                row_next = last_row ? '0 : row_reg + hvn_pkg::idx_t'(1);
            end
            else
            begin
                col_next = col_reg + hvn_pkg::idx_t'(1);
            end
        end
    end

    // The buffer selected by sel_reg holds the row two above and takes the current row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!sel_reg)
            begin
                buf0_mem[col_reg] <= height;
            end
            rd0_c_reg <= buf0_mem[col_reg];
            rd0_n_reg <= buf0_mem[addr_n];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (sel_reg)
            begin
                buf1_mem[col_reg] <= height;
            end
            rd1_c_reg <= buf1_mem[col_reg];
            rd1_n_reg <= buf1_mem[addr_n];
        end
    end

    always_comb
    begin
        s_t  = s_sel_reg ? rd1_c_reg : rd0_c_reg;
        s_m  = s_sel_reg ? rd0_c_reg : rd1_c_reg;
        s_mr = s_sel_reg ? rd0_n_reg : rd1_n_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_h_reg   <= height;
            s_row_reg <= row_reg;
            s_col_reg <= col_reg;
            s_sel_reg <= sel_reg;
            ml_reg    <= s_m;
            hl1_reg   <= s_h_reg;
            hl2_reg   <= hl1_reg;
        end
    end

    always_comb
    begin
        pick      = s_mask_reg & (~s_mask_reg + KIND_N'(1));
        out_free  = !out_valid_reg || out_ready;
        emit      = (s_mask_reg != '0) && out_free;
        mask_left = emit ? (s_mask_reg & ~pick) : s_mask_reg;
        in_ready  = (mask_left == '0);
        s_mask_next    = accept ? mask_in : mask_left;
        out_valid_next = out_free ? emit : out_valid_reg;
    end

    always_comb
    begin
        st.hu = s_m;
        st.hl = hl1_reg;
        st.h  = s_h_reg;
        st.hr = s_h_reg;
        st.hd = s_h_reg;
        st.vr = s_row_reg;
        st.vc = s_col_reg;
        case (pick)
            KIND_ABOVE:
            begin
                st.hu = s_t;
                st.hl = ml_reg;
                st.h  = s_m;
                st.hr = s_mr;
                st.vr = s_row_reg - hvn_pkg::idx_t'(1);
            end
            KIND_LAST_LAG:
            begin
                st.hu = ml_reg;
                st.hl = hl2_reg;
                st.h  = hl1_reg;
                st.vc = s_col_reg - hvn_pkg::idx_t'(1);
            end
            KIND_LAST_END:
            begin
                st.hu = s_m;
            end
            default:
            begin
                st.vr = s_row_reg;
            end
        endcase
    end

    hvn_stencil u_stencil (
        .side (side),
        .st   (st),
        .nrm  (nrm)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg      <= hvn_pkg::side_t'(hvn_pkg::SIDE_RESET);
            row_reg       <= '0;
            col_reg       <= '0;
            sel_reg       <= 1'b0;
            s_mask_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            side_reg      <= side_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            sel_reg       <= sel_next;
            s_mask_reg    <= s_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            normal_x_reg   <= nrm.x;
            normal_y_reg   <= nrm.y;
            normal_z_reg   <= nrm.z;
            vertex_row_reg <= st.vr;
            vertex_col_reg <= st.vc;
            frame_end_reg  <= nrm.frame_end;
            run_last_reg   <= ((s_mask_reg & ~pick) == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign normal_x   = normal_x_reg;
    assign normal_y   = normal_y_reg;
    assign normal_z   = normal_z_reg;
    assign vertex_row = vertex_row_reg;
    assign vertex_col = vertex_col_reg;
    assign frame_end  = frame_end_reg;
    assign run_last   = run_last_reg;

`ifndef SYNTH
    // A request is held off while its predecessor still has a normal waiting for the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_mask_reg != '0 && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("request accepted while a pending normal was blocked");

    // The stage keeps its height until the next request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(s_h_reg))
        else $error("stage height changed without a request");

    // The final vertex of the grid sits on the diagonal and closes its group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |->
            (run_last_reg && vertex_row_reg == vertex_col_reg))
        else $error("frame end on a wrong vertex");

    // Four quadrants are only possible away from the first row and column.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && normal_y_reg == hvn_pkg::ycount_t'(4)) |->
            (vertex_row_reg != '0 && vertex_col_reg != '0))
        else $error("interior normal reported on the border");
`endif

endmodule

FILE: src/hvn_stencil.sv
`timescale 1ns / 1ps
// Quadrant cross-product sum for one vertex and its four neighbor heights.
module hvn_stencil (
    input  hvn_pkg::side_t    side,
    input  hvn_pkg::stencil_t st,
    output hvn_pkg::normal_t  nrm
);

    hvn_pkg::side_t   vr_ext;
    hvn_pkg::side_t   vc_ext;
    logic             up;
    logic             down;
    logic             left;
    logic             right;
    hvn_pkg::comp_t   a;
    hvn_pkg::comp_t   b;
    hvn_pkg::comp_t   l;
    hvn_pkg::comp_t   r;
    hvn_pkg::comp_t   x;
    hvn_pkg::comp_t   z;
    hvn_pkg::ycount_t y;

    always_comb
    begin
        vr_ext = {1'b0, st.vr};
        vc_ext = {1'b0, st.vc};
        up     = (st.vr != '0);
        left   = (st.vc != '0);
        down   = ((vr_ext + hvn_pkg::side_t'(1)) < side);
        right  = ((vc_ext + hvn_pkg::side_t'(1)) < side);

        a = hvn_pkg::comp_t'($signed(st.hu)) - hvn_pkg::comp_t'($signed(st.h));
        b = hvn_pkg::comp_t'($signed(st.hd)) - hvn_pkg::comp_t'($signed(st.h));
        l = hvn_pkg::comp_t'($signed(st.hl)) - hvn_pkg::comp_t'($signed(st.h));
        r = hvn_pkg::comp_t'($signed(st.hr)) - hvn_pkg::comp_t'($signed(st.h));

        x = '0;
        z = '0;
        if (up && left)
        begin
            x = x + l;
            z = z + a;
        end
        if (left && down)
        begin
            x = x + l;
            z = z - b;
        end
        if (down && right)
        begin
            x = x - r;
            z = z - b;
        end
        if (right && up)
        begin
            x = x - r;
            z = z + a;
        end

        y = hvn_pkg::ycount_t'(up && left) + hvn_pkg::ycount_t'(left && down)
          + hvn_pkg::ycount_t'(down && right) + hvn_pkg::ycount_t'(right && up);

        nrm.x         = x;
        nrm.y         = y;
        nrm.z         = z;
        nrm.frame_end = ((vr_ext + hvn_pkg::side_t'(1)) == side)
                     && ((vc_ext + hvn_pkg::side_t'(1)) == side);
    end

endmodule

FILE: dv/hvn_normal_checker.sv
`timescale 1ns / 1ps
// Scoreboard that tracks the heightmap grid, predicts each vertex normal and checks the output.
module hvn_normal_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  hvn_pkg::side_t    cfg_wdata,
    input  logic              in_valid,
    input  logic              in_ready,
    input  hvn_pkg::height_t  height,
    input  logic              out_valid,
    input  logic              out_ready,
    input  hvn_pkg::comp_t    normal_x,
    input  hvn_pkg::ycount_t  normal_y,
    input  hvn_pkg::comp_t    normal_z,
    input  hvn_pkg::idx_t     vertex_row,
    input  hvn_pkg::idx_t     vertex_col,
    input  logic              frame_end,
    input  logic              run_last,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        hvn_pkg::comp_t   x;
        hvn_pkg::ycount_t y;
        hvn_pkg::comp_t   z;
        hvn_pkg::idx_t    row;
        hvn_pkg::idx_t    col;
        logic             frame_end;
        logic             run_last;
    } vertex_normal_t;

    hvn_pkg::height_t row_heights [2][hvn_pkg::MAX_SIDE];
    vertex_normal_t   normals_due [$];
    hvn_pkg::side_t   side_reg;
    int               next_row;
    int               next_col;
    int               mismatches;

    function automatic int grid_side();
        if (side_reg < hvn_pkg::MIN_SIDE)
            return hvn_pkg::MIN_SIDE;
        if (side_reg > hvn_pkg::MAX_SIDE)
            return hvn_pkg::MAX_SIDE;
        return int'(side_reg);
    endfunction

    function automatic vertex_normal_t vertex_normal(int vr, int vc, int n,
                                                     int hu, int hl, int h, int hr, int hd);
        vertex_normal_t v;
        bit             up;
        bit             down;
        bit             left;
        bit             right;
        int             x;
        int             y;
        int             z;
        up    = vr > 0;
        down  = vr + 1 < n;
        left  = vc > 0;
        right = vc + 1 < n;
        x = 0;
        y = 0;
        z = 0;
        if (up && left)
        begin
            x += hl - h;
            z += hu - h;
            y++;
        end
        if (left && down)
        begin
            x += hl - h;
            z -= hd - h;
            y++;
        end
        if (down && right)
        begin
            x -= hr - h;
            z -= hd - h;
            y++;
        end
        if (right && up)
        begin
            x -= hr - h;
            z += hu - h;
            y++;
        end
        v.x         = hvn_pkg::comp_t'(x);
        v.y         = hvn_pkg::ycount_t'(y);
        v.z         = hvn_pkg::comp_t'(z);
        v.row       = hvn_pkg::idx_t'(vr);
        v.col       = hvn_pkg::idx_t'(vc);
        v.frame_end = (vr + 1 == n) && (vc + 1 == n);
        v.run_last  = 1'b0;
        return v;
    endfunction

    // The current row overwrites the row two above it in the same buffer, column by column.
    function automatic void predict_height(hvn_pkg::height_t h_in);
        vertex_normal_t made [3];
        int             cnt;
        int             n;
        int             r;
        int             c;
        int             cur;
        int             prv;
        int             hl;
        int             hr;
        n   = grid_side();
        r   = next_row;
        c   = next_col;
        cur = r % 2;
        prv = 1 - cur;
        cnt = 0;
        if (r >= 1)
        begin
            hl = (c > 0) ? row_heights[prv][c - 1] : 0;
            hr = (c + 1 < n) ? row_heights[prv][c + 1] : 0;
            made[cnt] = vertex_normal(r - 1, c, n, row_heights[cur][c], hl,
                                      row_heights[prv][c], hr, h_in);
            cnt++;
        end
        if (r + 1 == n && c >= 1)
        begin
            hl = (c >= 2) ? row_heights[cur][c - 2] : 0;
            made[cnt] = vertex_normal(r, c - 1, n, row_heights[prv][c - 1], hl,
                                      row_heights[cur][c - 1], h_in, 0);
            cnt++;
        end
        if (r + 1 == n && c + 1 == n)
        begin
            made[cnt] = vertex_normal(r, c, n, row_heights[prv][c],
                                      row_heights[cur][c - 1], h_in, 0, 0);
            cnt++;
        end
        if (cnt > 0)
            made[cnt - 1].run_last = 1'b1;
        for (int i = 0; i < cnt; i++)
            normals_due = {normals_due, made[i]};
        row_heights[cur][c] = h_in;
        c++;
        if (c >= n)
        begin
            c = 0;
            r++;
            if (r >= n)
                r = 0;
        end
        next_row = r;
        next_col = c;
    endfunction

    function automatic void check_normal();
        vertex_normal_t got;
        vertex_normal_t want;
        got = {normal_x, normal_y, normal_z, vertex_row, vertex_col, frame_end, run_last};
        if (normals_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected normal for row %0d col %0d", vertex_row, vertex_col);
            return;
        end
        want = normals_due.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("normal mismatch:");
                $display("  expected x=%0d y=%0d z=%0d row=%0d col=%0d end=%0b last=%0b",
                         want.x, want.y, want.z, want.row, want.col, want.frame_end,
                         want.run_last);
                $display("  actual   x=%0d y=%0d z=%0d row=%0d col=%0d end=%0b last=%0b",
                         got.x, got.y, got.z, got.row, got.col, got.frame_end,
                         got.run_last);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg   = hvn_pkg::side_t'(hvn_pkg::SIDE_RESET);
            next_row   = 0;
            next_col   = 0;
            mismatches = 0;
            normals_due.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_normal();
            if (cfg_we)
            begin
                side_reg = cfg_wdata;
                next_row = 0;
                next_col = 0;
            end
            if (in_valid && in_ready)
                predict_height(height);
            fail_count <= mismatches;
            pending    <= normals_due.size();
        end
    end

endmodule

FILE: dv/heightmap_vertex_normals_core_test.sv
`timescale 1ns / 1ps
// Testbench top that streams heightmap grids into the vertex normal core and reports the verdict.
module heightmap_vertex_normals_core_test;

    localparam int RANDOM_ITEMS  = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    hvn_pkg::side_t   cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    hvn_pkg::height_t height;
    logic             out_valid;
    logic             out_ready;
    hvn_pkg::comp_t   normal_x;
    hvn_pkg::ycount_t normal_y;
    hvn_pkg::comp_t   normal_z;
    hvn_pkg::idx_t    vertex_row;
    hvn_pkg::idx_t    vertex_col;
    logic             frame_end;
    logic             run_last;
    int               fail_count;
    int               pending;
    int               in_idle_pct;
    int               out_stall_pct;
    bit               hold_toggle;
    bit               hold_seen;
    int               hold_left;

    heightmap_vertex_normals_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .height     (height),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .vertex_row (vertex_row),
        .vertex_col (vertex_col),
        .frame_end  (frame_end),
        .run_last   (run_last)
    );

    hvn_normal_checker normal_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .height     (height),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .vertex_row (vertex_row),
        .vertex_col (vertex_col),
        .frame_end  (frame_end),
        .run_last   (run_last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // A toggle of hold_toggle starts a long stretch with the output held off.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_seen <= hold_toggle;
            hold_left <= 0;
            out_ready <= 1'b0;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    task automatic set_idling(input idle_mode_t mode);
        in_idle_pct = (mode == IDLE_SENDER) ? 88 : (mode == IDLE_BOTH) ? 11 : 0;
        out_stall_pct <= (mode == IDLE_RECEIVER) ? 88 : (mode == IDLE_BOTH) ? 11 : 0;
    endtask

    // Each request stays offered, unchanged, until the core takes it.
    task automatic send_height(input hvn_pkg::height_t h);
        int gap;
        gap = 0;
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        height   <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_side(input hvn_pkg::side_t v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic hvn_pkg::height_t rand_height();
        if ($urandom_range(7) == 0)
            return ($urandom_range(1) != 0) ? hvn_pkg::height_t'(16'h7FFF)
                                            : hvn_pkg::height_t'(16'h8000);
        return hvn_pkg::height_t'($urandom);
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_height(rand_height());
    endtask

    initial
    begin
        hvn_pkg::height_t corners [4];
        hvn_pkg::height_t steep_a [9];
        hvn_pkg::height_t steep_b [9];
        int               random_sent;
        int               phase;
        int               pick;
        int               side;
        int               n;
        int               cells;
        int               pause_at;

        corners = '{32767, -32768, -32768, 32767};
        steep_a = '{0, -32768, 0, 32767, 0, -32768, 0, 32767, 0};
        steep_b = '{-1, 32767, -1, -32768, -1, 32767, 0, -32768, 0};

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        in_valid      <= 1'b0;
        height        <= '0;
        hold_toggle   <= 1'b0;
        in_idle_pct   = 0;
        out_stall_pct <= 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A few heights at the side after reset, then corner-only and steepest grids, then sides 0 and 1.
        send_random(6);
        write_side(hvn_pkg::side_t'(2));
        foreach (corners[i])
            send_height(corners[i]);
        write_side(hvn_pkg::side_t'(3));
        foreach (steep_a[i])
            send_height(steep_a[i]);
        foreach (steep_b[i])
            send_height(steep_b[i]);
        write_side(hvn_pkg::side_t'(0));
        send_random(4);
        write_side(hvn_pkg::side_t'(1));
        send_random(2);

        // Sides above the limit act as the largest grid; only a few heights are sent.
        write_side(hvn_pkg::side_t'(2047));
        send_random(6);
        write_side(hvn_pkg::side_t'(1025));
        send_random(6);

        write_side(hvn_pkg::side_t'(8));
        hold_toggle <= ~hold_toggle;
        send_random(40);
        drain_results();
        send_random(24);

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(9);
            side = (pick == 0) ? $urandom_range(1) :
                   (pick == 1) ? $urandom_range(9, 12) : $urandom_range(2, 8);
            write_side(hvn_pkg::side_t'(side));
            set_idling(idle_mode_t'(phase % 4));
            n     = (side < hvn_pkg::MIN_SIDE) ? hvn_pkg::MIN_SIDE : side;
            cells = n * n;
            if ($urandom_range(7) == 0)
                cells = $urandom_range(1, cells - 1);
            else if ($urandom_range(3) == 0)
                cells = 2 * cells;
            if (cells > RANDOM_ITEMS / 4)
                cells = RANDOM_ITEMS / 4;
            pause_at = ($urandom_range(3) == 0) ? cells / 2 : -1;
            for (int i = 0; i < cells; i++)
            begin
                if (i == pause_at && i != 0)
                    drain_results();
                send_height(rand_height());
            end
            random_sent += cells;
            phase++;
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
